@@ design/elimination_tree_builder_unit_assert.svh @@
// Assertion macros for the elimination tree builder.
// Included by the top level; no other dependencies.
`ifndef ELIMINATION_TREE_BUILDER_UNIT_ASSERT_SVH
`define ELIMINATION_TREE_BUILDER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define ETB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ETB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/etb_pkg.sv @@
// Package for the elimination tree builder: widths, payload structs, codes.
// No dependencies.
`timescale 1ns / 1ps

package etb_pkg;

   localparam int NODE_W    = 10;
   localparam int MAX_NODES = 1 << NODE_W;
   localparam int COUNT_W   = NODE_W + 1;
   localparam int EPOCH_W   = 3;
   localparam int WORD_W    = EPOCH_W + NODE_W;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(MAX_NODES);
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   localparam logic KIND_PARENT = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef struct packed {
      logic [NODE_W-1:0] row_index;
      logic [NODE_W-1:0] column_index;
      logic              start_matrix;
   } req_type;

   typedef struct packed {
      logic              result_kind;
      logic [NODE_W-1:0] child_node;
      logic [NODE_W-1:0] parent_node;
   } rsp_type;

endpackage

@@ design/elimination_tree_builder_unit.sv @@
// Elimination tree builder top level: ancestor memory, walk sequencer, result register.
// Depends on etb_pkg and elimination_tree_builder_unit_assert.svh.
//
// Usage: feed upper-triangle nonzeros (row < column) on the req_ channel in
// non-decreasing column order; set start_matrix on the first entry of a matrix.
// Each entry walks the ancestor memory from the row toward the column, one hop
// per cycle, pointing each visited node at the column. A node with no ancestor
// gets the column as tree parent and one rsp_ transfer reports it. Entries with
// row not below column, or column not below node_count, give one reject transfer.
// Timing: a rejected entry passes through ST_CHECK, which loads its result into the
// rsp_ register and returns to ST_IDLE for the next entry. Otherwise the walk visits
// one node per cycle, set by the registered read of the ancestor memory: ST_CHECK
// issues the first read, ST_HOP follows one link per node and, as the walk ends, loads
// any result and returns to ST_IDLE. Compressed paths keep the walk short on average.
// The ancestor memory carries a matrix epoch tag per entry. A start_matrix bumps
// the epoch; every seventh matrix, and after reset, a clearing pass over every entry
// runs with req_stall high. csr_ writes of node_count are always taken.
// A stalled rsp_ holds its transfer; the next entry is taken meanwhile and its
// walk pauses only when it has a result to deliver.
`timescale 1ns / 1ps

`include "elimination_tree_builder_unit_assert.svh"

module elimination_tree_builder_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  etb_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output etb_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [etb_pkg::COUNT_W-1:0] csr_data
);

   import etb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_HOP   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic               pend_ff, pend_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [WORD_W-1:0]  link_mem [MAX_NODES];
   logic               mem_wr_en;
   logic [NODE_W-1:0]  mem_wr_addr;
   logic [WORD_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [NODE_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0]  mem_rd_data_ff;
   logic               fwd_ff;
   logic [WORD_W-1:0]  fwd_data_ff;

   logic               req_fire;
   logic               rsp_free;
   logic               rsp_load;
   logic               reject;
   logic [WORD_W-1:0]  rd_word;
   logic [EPOCH_W-1:0] rd_tag;
   logic [NODE_W-1:0]  rd_link;
   logic               hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign reject  = (item_ff.row_index >= item_ff.column_index) ||
                    ({1'b0, item_ff.column_index} >= count_ff);
   assign rd_word = fwd_ff ? fwd_data_ff : mem_rd_data_ff;
   assign rd_tag  = rd_word[NODE_W +: EPOCH_W];
   assign rd_link = rd_word[NODE_W-1:0];
   assign hit     = (rd_tag == epoch_ff);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      pend_in      = pend_ff;
      epoch_in     = epoch_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      count_in     = (csr_valid && csr_ready) ? csr_data : count_ff;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = node_ff;
      mem_wr_data  = {epoch_ff, item_ff.column_index};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = item_ff.row_index;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in = req_data;
               pend_in = 1'b1;
               state_in = ST_CHECK;
               if (req_data.start_matrix) begin
                  if (epoch_ff == EPOCH_LAST) begin
                     epoch_in = EPOCH_FIRST;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
               end
            end
         end
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = {EPOCH_NONE, {NODE_W{1'b0}}};
            clr_in      = clr_ff + NODE_W'(1);
            if (clr_ff == {NODE_W{1'b1}}) begin
               state_in = pend_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (reject) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  rsp_in   = '{result_kind: KIND_REJECT,
                               child_node:  item_ff.row_index,
                               parent_node: item_ff.column_index};
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = item_ff.row_index;
               node_in     = item_ff.row_index;
               state_in    = ST_HOP;
            end
         end
         ST_HOP: begin
            if (!hit) begin
               if (rsp_free) begin
                  mem_wr_en = 1'b1;
                  rsp_load  = 1'b1;
                  rsp_in    = '{result_kind: KIND_PARENT,
                                child_node:  node_ff,
                                parent_node: item_ff.column_index};
                  pend_in   = 1'b0;
                  state_in  = ST_IDLE;
               end
            end else begin
               mem_wr_en = 1'b1;
               if (rd_link == item_ff.column_index) begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = rd_link;
                  node_in     = rd_link;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         epoch_ff     <= EPOCH_FIRST;
         clr_ff       <= '0;
         count_ff     <= NODE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      node_ff <= node_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         link_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_rd_data_ff <= link_mem[mem_rd_addr];
         fwd_ff         <= mem_wr_en && (mem_wr_addr == mem_rd_addr);
         fwd_data_ff    <= mem_wr_data;
      end
   end

   `ETB_ASSERT_IMPLY(a_clear_blocks, clock, reset, state_ff == ST_CLEAR, req_stall,
      "entry taken during clearing pass")
   `ETB_ASSERT_IMPLY(a_parent_differs, clock, reset,
      rsp_load && (rsp_in.result_kind == KIND_PARENT),
      rsp_in.child_node != rsp_in.parent_node, "node reported as its own parent")
   `ETB_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_CHECK) || $past(state_ff == ST_HOP),
      "result raised outside check or walk")
   `ETB_ASSERT_ALWAYS(a_epoch_live, clock, reset, epoch_ff != EPOCH_NONE,
      "epoch collides with cleared tag")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for elimination_tree_builder_unit: directed and random entry streams.
// Predicts parent links and rejects with its own ancestor table; needs etb_pkg and the design.
`timescale 1ns / 1ps

module testbench;
   import etb_pkg::*;

   typedef enum int {
      NOISE_DIAGONAL,
      NOISE_ROW_ABOVE,
      NOISE_ANY_COLUMN,
      NOISE_RESTART
   } noise_kind_type;

   localparam int SETTLE_CYCLES = MAX_NODES + 100;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   logic [COUNT_W-1:0] node_count_cfg = NODE_COUNT_RESET;
   logic [NODE_W-1:0]  ancestor_of [MAX_NODES];
   logic [MAX_NODES-1:0] has_ancestor = '0;

   rsp_type     expected_results [$];
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned entries_sent = 0;
   int unsigned matrices_started = 0;
   int unsigned parents_seen = 0;
   int unsigned rejects_seen = 0;
   int unsigned settings_used = 0;

   elimination_tree_builder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned node_limit();
      return (int'(node_count_cfg) < MAX_NODES) ? int'(node_count_cfg) : MAX_NODES;
   endfunction

   function automatic bit predict_tree_link(input req_type item, output rsp_type outcome);
      int unsigned       hops;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] next_node;
      outcome = '0;
      if (item.start_matrix) has_ancestor = '0;
      if (item.row_index >= item.column_index ||
          int'(item.column_index) >= node_limit()) begin
         outcome.result_kind = KIND_REJECT;
         outcome.child_node  = item.row_index;
         outcome.parent_node = item.column_index;
         return 1'b1;
      end
      node = item.row_index;
      hops = 0;
      while (node != item.column_index && hops <= MAX_NODES) begin
         hops++;
         if (!has_ancestor[node]) begin
            has_ancestor[node] = 1'b1;
            ancestor_of[node]  = item.column_index;
            outcome.result_kind = KIND_PARENT;
            outcome.child_node  = node;
            outcome.parent_node = item.column_index;
            return 1'b1;
         end
         next_node = ancestor_of[node];
         ancestor_of[node] = item.column_index;
         node = next_node;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99, 0) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_data.result_kind == KIND_PARENT) parents_seen++;
         else rejects_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_data.result_kind !== oldest.result_kind) begin
               $display("%0t: result_kind expected %h actual %h", $time,
                        oldest.result_kind, rsp_data.result_kind);
               error_count++;
            end
            if (rsp_data.child_node !== oldest.child_node) begin
               $display("%0t: child_node expected %0d actual %0d", $time,
                        oldest.child_node, rsp_data.child_node);
               error_count++;
            end
            if (rsp_data.parent_node !== oldest.parent_node) begin
               $display("%0t: parent_node expected %0d actual %0d", $time,
                        oldest.parent_node, rsp_data.parent_node);
               error_count++;
            end
         end
      end
   end

   task automatic send_entry(input req_type item);
      rsp_type outcome;
      if ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (predict_tree_link(item, outcome)) expected_results = {expected_results, outcome};
      entries_sent++;
      if (item.start_matrix) matrices_started++;
   endtask

   task automatic send_fields(input int unsigned row, input int unsigned col,
                              input logic start);
      req_type item;
      item.row_index    = NODE_W'(row);
      item.column_index = NODE_W'(col);
      item.start_matrix = start;
      send_entry(item);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic write_node_count(input logic [COUNT_W-1:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      node_count_cfg = value;
      settings_used++;
   endtask

   task automatic send_random_matrix(input int unsigned size, input int unsigned budget,
                                     inout int unsigned sent);
      req_type     item;
      int unsigned col;
      int unsigned rows;
      int unsigned k;
      int unsigned step;
      int unsigned count;
      logic        first;
      col   = 1;
      count = 0;
      first = 1'b1;
      step  = (size > 64) ? size / 32 : 1;
      while (col < size && count < budget) begin
         rows = $urandom_range(3, 0);
         for (k = 0; k < rows && count < budget; k++) begin
            item.row_index    = NODE_W'($urandom_range(col - 1, 0));
            item.column_index = NODE_W'(col);
            item.start_matrix = first;
            if ($urandom_range(99, 0) < 6) begin
               case (noise_kind_type'($urandom_range(3, 0)))
                  NOISE_DIAGONAL:   item.row_index = item.column_index;
                  NOISE_ROW_ABOVE:  item.row_index = NODE_W'($urandom_range(MAX_NODES - 1, col));
                  NOISE_ANY_COLUMN: begin
                     item.row_index    = NODE_W'($urandom_range(MAX_NODES - 1, 0));
                     item.column_index = NODE_W'($urandom_range(MAX_NODES - 1, 0));
                  end
                  NOISE_RESTART:    item.start_matrix = 1'b1;
                  default:          item.start_matrix = first;
               endcase
            end
            send_entry(item);
            first = 1'b0;
            count++;
         end
         col += $urandom_range(step, 1);
      end
      sent += count;
   endtask

   task automatic run_random_phase(input int unsigned sender_idle, input int unsigned recv_stall,
                                   input logic [COUNT_W-1:0] count_value,
                                   input int unsigned item_target, input bit hold_midway);
      int unsigned sent;
      int unsigned size;
      int unsigned limit;
      bit          held;
      write_node_count(count_value);
      idle_pct  = sender_idle;
      stall_pct = recv_stall;
      limit = node_limit();
      sent  = 0;
      held  = 1'b0;
      while (sent < item_target) begin
         if ($urandom_range(99, 0) < 10) size = limit;
         else size = $urandom_range((limit < 40) ? limit : 40, 2);
         send_random_matrix(size, $urandom_range(40, 4), sent);
         if (hold_midway && !held && sent >= item_target / 2) begin
            wait_for_results();
            held = 1'b1;
         end
      end
      wait_for_results();
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   task automatic test_tree_walk();
      write_node_count(COUNT_W'(8));
      send_fields(0, 1, 1'b1);
      send_fields(1, 2, 1'b0);
      send_fields(0, 2, 1'b0);
      send_fields(2, 2, 1'b0);
      send_fields(3, 2, 1'b0);
      send_fields(3, 4, 1'b0);
      send_fields(2, 4, 1'b0);
      send_fields(0, 4, 1'b0);
      send_fields(5, 8, 1'b0);
      send_fields(7, 7, 1'b1);
      send_fields(0, 1, 1'b0);
      send_fields(4, 6, 1'b0);
      send_fields(2, 3, 1'b0);
   endtask

   task automatic test_extreme_indices();
      write_node_count('1);
      send_fields(0, MAX_NODES - 1, 1'b1);
      send_fields(MAX_NODES - 2, MAX_NODES - 1, 1'b0);
      send_fields(MAX_NODES - 1, MAX_NODES - 1, 1'b0);
      send_fields(MAX_NODES - 1, 0, 1'b0);
      send_fields(MAX_NODES / 2 - 1, MAX_NODES / 2, 1'b0);
   endtask

   task automatic test_node_count_extremes();
      write_node_count('0);
      send_fields(0, 1, 1'b1);
      send_fields(0, MAX_NODES - 1, 1'b0);
      write_node_count(COUNT_W'(1));
      send_fields(0, 1, 1'b1);
      write_node_count(COUNT_W'(2));
      send_fields(0, 1, 1'b1);
      send_fields(1, 2, 1'b0);
      send_fields(0, 1, 1'b0);
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, NODE_COUNT_RESET, 375, 1'b0);
      run_random_phase(46, 0, COUNT_W'($urandom_range(MAX_NODES, 2)), 375, 1'b0);
      run_random_phase(0, 46, '1, 375, 1'b0);
      run_random_phase(38, 38, COUNT_W'($urandom_range(200, 2)), 375, 1'b1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tree_walk();
      test_extreme_indices();
      test_node_count_extremes();
      test_random_traffic();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d entries in %0d matrices over %0d node_count settings",
               entries_sent, matrices_started, settings_used);
      $display("observed %0d parent links and %0d rejected entries, %0d mismatches",
               parents_seen, rejects_seen, error_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/etb_pkg.sv
design/elimination_tree_builder_unit.sv
tb/sv/testbench.sv
